// ===== rtl/btlv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package btlv_pkg;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_ERROR  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   localparam logic [2:0] ERR_TAG_PAST_END = 3'd0;
   localparam logic [2:0] ERR_TAG_TOO_LONG = 3'd1;
   localparam logic [2:0] ERR_NO_LENGTH    = 3'd2;
   localparam logic [2:0] ERR_BAD_LENGTH   = 3'd3;
   localparam logic [2:0] ERR_OVERRUN      = 3'd4;
   localparam logic [2:0] ERR_TOO_DEEP     = 3'd5;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_TAG     = 3'd1;
   localparam logic [2:0] PH_TAGMORE = 3'd2;
   localparam logic [2:0] PH_LEN     = 3'd3;
   localparam logic [2:0] PH_LENMORE = 3'd4;
   localparam logic [2:0] PH_VALUE   = 3'd5;
   localparam logic [2:0] PH_SKIP    = 3'd6;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] tag;
      logic [2:0]  tag_bytes;
      logic [15:0] value_length;
      logic        constructed;
      logic [2:0]  depth;
      logic [15:0] value_offset;
      logic [2:0]  error_code;
      logic        message_done;
   } result_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] msg_length;
      logic [7:0]  data_byte;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/btlv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface btlv_req_if;
   logic                  valid;
   logic                  ready;
   btlv_pkg::item_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface btlv_rsp_if;
   logic                  valid;
   logic                  ready;
   btlv_pkg::result_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/ber_tlv_stream_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ber-tlv stream parser: takes one request transfer per cycle (a start carrying the
// message length, or one message byte) and gives at most one response transfer per
// byte (element header, error, or message done); the front walks tag and length
// fields a byte a cycle and a two-entry response queue lets the sink stall on its
// own, with request ready held low only while that queue is full
module ber_tlv_stream_parser #(
   parameter int MAX_DEPTH     = 8,
   parameter int MAX_TAG_BYTES = 4,
   parameter int OFFSET_BITS   = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   btlv_req_if.sink   req,
   btlv_rsp_if.source rsp
);
   logic                 res_valid;
   logic                 room;
   btlv_pkg::result_type res_item;

   // parser front: state per byte
   btlv_front #(
      .MAX_DEPTH    (MAX_DEPTH),
      .MAX_TAG_BYTES(MAX_TAG_BYTES),
      .OFFSET_BITS  (OFFSET_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_item  (req.payload),
      .res_valid(res_valid),
      .res_item (res_item),
      .res_ready(room)
   );

   // response queue decouples the sink
   btlv_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(res_valid),
      .wr_item (res_item),
      .wr_room (room),
      .rsp     (rsp)
   );
endmodule
`default_nettype wire

// ===== rtl/btlv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module btlv_front #(
   parameter int MAX_DEPTH     = 8,
   parameter int MAX_TAG_BYTES = 4,
   parameter int OFFSET_BITS   = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  btlv_pkg::item_type        in_item,
   output logic                      res_valid,
   output btlv_pkg::result_type      res_item,
   input  wire logic                 res_ready
);
   localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CW = $clog2(MAX_TAG_BYTES + 2);
   localparam int PW = OFFSET_BITS + 1;

   logic [OFFSET_BITS-1:0] lend_ff [MAX_DEPTH];
   logic [OFFSET_BITS-1:0] lend_in [MAX_DEPTH];
   logic [LW-1:0]          lvl_ff, lvl_in;
   logic [2:0]             ph_ff, ph_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [31:0]            tag_ff, tag_in;
   logic [CW-1:0]          tcnt_ff, tcnt_in;
   logic [31:0]            len_ff, len_in;
   logic [2:0]             lleft_ff, lleft_in;
   logic                   cons_ff, cons_in;

   logic                   fire;
   logic                   have;
   btlv_pkg::result_type   r;
   logic [7:0]             b;
   logic [OFFSET_BITS-1:0] p, e, rem, v, lvl_endv;
   logic [PW-1:0]          p1;
   logic [31:0]            avail;
   logic [7:0]             n;
   logic                   pop_ok;

   assign in_ready = res_ready;
   assign fire     = in_valid && in_ready;

   // fill one response from the decoded fields
   function automatic void put(
      output btlv_pkg::result_type o, input logic [1:0] k, input logic [2:0] c,
      input logic [OFFSET_BITS-1:0] off, input logic [31:0] t, input logic [CW-1:0] tc,
      input logic [31:0] l, input logic cs, input logic [LW-1:0] lv);
      o = '0;
      o.kind         = k;
      o.tag          = t;
      o.tag_bytes    = 3'(tc);
      o.value_length = l[15:0];
      o.constructed  = cs;
      o.depth        = 3'(lv);
      o.value_offset = 16'(off);
      o.error_code   = c;
   endfunction

   always_comb begin
      lend_in  = lend_ff;
      lvl_in   = lvl_ff;
      ph_in    = ph_ff;
      pos_in   = pos_ff;
      tag_in   = tag_ff;
      tcnt_in  = tcnt_ff;
      len_in   = len_ff;
      lleft_in = lleft_ff;
      cons_in  = cons_ff;
      have     = 1'b0;
      r        = '0;
      b        = in_item.data_byte;
      p        = pos_ff;
      p1       = {1'b0, pos_ff} + PW'(1);
      v        = p1[OFFSET_BITS-1:0];
      e        = '0;
      rem      = '0;
      avail    = '0;
      n        = '0;
      pop_ok   = 1'b0;
      lvl_endv = '0;
      if (in_item.cmd == btlv_pkg::CMD_START) begin
         for (int i = 0; i < MAX_DEPTH; i++) lend_in[i] = '0;
         lend_in[0] = OFFSET_BITS'(in_item.msg_length);
         lvl_in   = '0;
         pos_in   = '0;
         tag_in   = '0;
         tcnt_in  = '0;
         len_in   = '0;
         lleft_in = '0;
         cons_in  = 1'b0;
         ph_in    = (OFFSET_BITS'(in_item.msg_length) != '0) ? btlv_pkg::PH_TAG
                                                           : btlv_pkg::PH_IDLE;
      end else if (ph_ff != btlv_pkg::PH_IDLE) begin
         if (ph_ff == btlv_pkg::PH_VALUE && 32'(p) >= len_ff) ph_in = btlv_pkg::PH_TAG;
         // several level ends may coincide, so close every level that ends here
         if (ph_in == btlv_pkg::PH_TAG || ph_in == btlv_pkg::PH_SKIP) begin
            for (int i = MAX_DEPTH - 1; i >= 1; i--) begin
               if (LW'(i) <= lvl_ff) begin
                  if (!pop_ok && p < lend_ff[i]) begin
                     pop_ok = 1'b1;
                  end
                  if (!pop_ok) begin
                     lvl_in = LW'(i - 1);
                     ph_in  = btlv_pkg::PH_TAG;
                  end
               end
            end
         end
         e   = lend_ff[lvl_in];
         rem = (e > p) ? e - p : '0;
         unique case (ph_in)
            btlv_pkg::PH_TAG: begin
               if (rem < OFFSET_BITS'(3)) begin
                  ph_in = btlv_pkg::PH_SKIP;
               end else begin
                  tag_in   = {24'd0, b};
                  tcnt_in  = CW'(1);
                  cons_in  = b[5];
                  len_in   = '0;
                  lleft_in = '0;
                  if (b[4:0] == 5'h1F) begin
                     ph_in = btlv_pkg::PH_TAGMORE;
                  end else if (rem <= OFFSET_BITS'(1)) begin
                     put(r, btlv_pkg::KIND_ERROR, btlv_pkg::ERR_NO_LENGTH, p, tag_in,
                         tcnt_in, len_in, cons_in, lvl_in);
                     have  = 1'b1;
                     ph_in = btlv_pkg::PH_SKIP;
                  end else begin
                     ph_in = btlv_pkg::PH_LEN;
                  end
               end
            end
            btlv_pkg::PH_TAGMORE: begin
               tag_in  = {tag_ff[23:0], b};
               tcnt_in = tcnt_ff + CW'(1);
               if (tcnt_in > CW'(MAX_TAG_BYTES)) begin
                  put(r, btlv_pkg::KIND_ERROR, btlv_pkg::ERR_TAG_TOO_LONG, p, tag_in,
                      tcnt_in, len_in, cons_in, lvl_in);
                  have  = 1'b1;
                  ph_in = btlv_pkg::PH_SKIP;
               end else if (!b[7]) begin
                  if (rem <= OFFSET_BITS'(1)) begin
                     put(r, btlv_pkg::KIND_ERROR, btlv_pkg::ERR_NO_LENGTH, p, tag_in,
                         tcnt_in, len_in, cons_in, lvl_in);
                     have  = 1'b1;
                     ph_in = btlv_pkg::PH_SKIP;
                  end else begin
                     ph_in = btlv_pkg::PH_LEN;
                  end
               end else if (rem <= OFFSET_BITS'(1)) begin
                  put(r, btlv_pkg::KIND_ERROR, btlv_pkg::ERR_TAG_PAST_END, p, tag_in,
                      tcnt_in, len_in, cons_in, lvl_in);
                  have  = 1'b1;
                  ph_in = btlv_pkg::PH_SKIP;
               end
            end
            btlv_pkg::PH_LEN, btlv_pkg::PH_LENMORE: begin
               if (ph_in == btlv_pkg::PH_LEN) begin
                  n = {1'b0, b[6:0]};
                  if (b[7] && (32'(n) + 32'd1 > 32'(rem) || n > 8'd4)) begin
                     put(r, btlv_pkg::KIND_ERROR, btlv_pkg::ERR_BAD_LENGTH, p, tag_ff,
                         tcnt_ff, len_ff, cons_ff, lvl_in);
                     have  = 1'b1;
                     ph_in = btlv_pkg::PH_SKIP;
                  end else if (b[7] && n != 8'd0) begin
                     len_in   = '0;
                     lleft_in = n[2:0];
                     ph_in    = btlv_pkg::PH_LENMORE;
                  end else begin
                     len_in = b[7] ? 32'd0 : {24'd0, b};
                     have   = 1'b1;
                  end
               end else begin
                  len_in = {len_ff[23:0], b};
                  if (lleft_ff != 3'd0) lleft_in = lleft_ff - 3'd1;
                  have = (lleft_in == 3'd0);
               end
               if (have && ph_in != btlv_pkg::PH_SKIP) begin
                  avail = (p1 < {1'b0, e}) ? 32'(e) - 32'(p1) : 32'd0;
                  if (len_in > avail) begin
                     put(r, btlv_pkg::KIND_ERROR, btlv_pkg::ERR_OVERRUN, v, tag_ff,
                         tcnt_ff, len_in, cons_ff, lvl_in);
                     ph_in = btlv_pkg::PH_SKIP;
                  end else begin
                     lvl_endv = v + len_in[OFFSET_BITS-1:0];
                     if (cons_ff && 32'(lvl_in) + 32'd1 < 32'(MAX_DEPTH)) begin
                        put(r, btlv_pkg::KIND_HEADER, 3'd0, v, tag_ff, tcnt_ff, len_in,
                            cons_ff, lvl_in);
                        lvl_in          = lvl_in + LW'(1);
                        lend_in[lvl_in] = lvl_endv;
                        ph_in           = btlv_pkg::PH_TAG;
                     end else begin
                        put(r, cons_ff ? btlv_pkg::KIND_ERROR : btlv_pkg::KIND_HEADER,
                            cons_ff ? btlv_pkg::ERR_TOO_DEEP : 3'd0, v, tag_ff, tcnt_ff,
                            len_in, cons_ff, lvl_in);
                        len_in = 32'(lvl_endv);
                        ph_in  = (r.value_length != 16'd0 || len_in != 32'(v))
                                 ? btlv_pkg::PH_VALUE : btlv_pkg::PH_TAG;
                     end
                  end
               end
            end
            default: ;
         endcase
         pos_in = v;
         if (p1 >= {1'b0, lend_ff[0]}) begin
            ph_in = btlv_pkg::PH_IDLE;
            if (!have) begin
               r      = '0;
               r.kind = btlv_pkg::KIND_DONE;
               have   = 1'b1;
            end
            r.message_done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DEPTH; i++) lend_ff[i] <= '0;
         lvl_ff   <= '0;
         ph_ff    <= btlv_pkg::PH_IDLE;
         pos_ff   <= '0;
         tag_ff   <= '0;
         tcnt_ff  <= '0;
         len_ff   <= '0;
         lleft_ff <= '0;
         cons_ff  <= 1'b0;
      end else if (fire) begin
         lend_ff  <= lend_in;
         lvl_ff   <= lvl_in;
         ph_ff    <= ph_in;
         pos_ff   <= pos_in;
         tag_ff   <= tag_in;
         tcnt_ff  <= tcnt_in;
         len_ff   <= len_in;
         lleft_ff <= lleft_in;
         cons_ff  <= cons_in;
      end
   end

   assign res_valid = fire && have;
   assign res_item  = r;
endmodule
`default_nettype wire

// ===== rtl/btlv_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module btlv_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_valid,
   input  btlv_pkg::result_type wr_item,
   output logic                 wr_room,
   btlv_rsp_if.source           rsp
);
   btlv_pkg::result_type slot_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;
   logic       pop, push;

   assign wr_room     = (cnt_ff != 2'd2);
   assign push        = wr_valid;
   assign pop         = rsp.valid && rsp.ready;
   assign rsp.valid   = (cnt_ff != 2'd0);
   assign rsp.payload = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= wr_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/btlv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module btlv_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic rsp_done,
   input wire logic [2:0] rsp_code
);
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != 2'd3) else $error("bad kind");
   a_done_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == btlv_pkg::KIND_DONE |-> rsp_done) else $error("done");
   a_hdr_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == btlv_pkg::KIND_HEADER |-> rsp_code == 3'd0)
      else $error("header code");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("dropped");
endmodule

bind ber_tlv_stream_parser btlv_checker u_chk (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_kind (rsp.payload.kind),
   .rsp_done (rsp.payload.message_done),
   .rsp_code (rsp.payload.error_code)
);
`default_nettype wire
